// File: hdl/nclfsr_pkg.sv
`timescale 1ns / 1ps

package nclfsr_pkg;

    // widths fixed by the register and field layout
    localparam int KIND_W   = 2;
    localparam int CYC_W    = 8;
    localparam int LFSR_W   = 15;
    localparam int ACC_W    = 22;
    localparam int VOL_W    = 4;
    localparam int ENV_W    = 3;
    localparam int LEN_W    = 7;
    localparam int SHIFT_W  = 4;
    localparam int RATIO_W  = 3;
    localparam int SLEN_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam int BASE_DIVISOR_DEF = 16;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h7FFF;
    localparam logic [ACC_W-1:0]  ACC_MAX   = 22'h3FFFFF;
    localparam logic [VOL_W-1:0]  VOL_MAX   = 4'd15;
    localparam logic [VOL_W-1:0]  VOL_MIN   = 4'd0;
    localparam logic [LEN_W-1:0]  LEN_FULL  = 7'd64;

    // request queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // incoming kind codes
    localparam logic [KIND_W-1:0] KIND_ADVANCE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENVELOPE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TRIGGER  = 2'd3;

    typedef enum logic [1:0] {
        OP_ADVANCE,
        OP_LENGTH,
        OP_ENVELOPE,
        OP_TRIGGER
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFT_CLOCK,
        CFG_DIVIDE_RATIO,
        CFG_NARROW_MODE,
        CFG_LENGTH_ENABLE,
        CFG_SOUND_LENGTH,
        CFG_INITIAL_VOLUME,
        CFG_ENVELOPE_UP,
        CFG_ENVELOPE_PERIOD
    } cfg_idx_t;

    typedef struct packed {
        op_t              op;
        logic [CYC_W-1:0] cycles;
    } req_t;

endpackage

// File: hdl/noise_channel_lfsr_envelope.sv
`timescale 1ns / 1ps

// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata: cycles; s_tuser: kind
// m_      | out | m_tvalid/m_tready  | m_tdata: level, channel_on
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while m_tready stays high; a taken request passes
// through the front register, the two-entry queue and the output register, in
// that order, before it shows on m_tvalid.
// aresetn is synchronous and clears the state directly, with no clearing pass.
// A stalled m_ side backs up into the queue, then the front register, and only
// then drops s_tready. cfg_ready is always high.

module noise_channel_lfsr_envelope
    import nclfsr_pkg::*;
#(
    parameter int BASE_DIVISOR = BASE_DIVISOR_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] cycles
    input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [3:0] level, [4] channel_on, [7:5] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic             q_in_valid, q_in_ready;
    req_t             q_in_req;
    logic             q_out_valid, q_out_ready;
    req_t             q_out_req;
    logic [VOL_W-1:0] level;
    logic             channel_on;

    nclfsr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cycles (s_tdata[CYC_W-1:0]),
        .s_kind   (s_tuser),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_req    (q_in_req)
    );

    nclfsr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_req    (q_in_req),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_req   (q_out_req)
    );

    nclfsr_back #(
        .BASE_DIVISOR (BASE_DIVISOR)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_out_valid),
        .q_ready      (q_out_ready),
        .q_req        (q_out_req),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_level      (level),
        .m_channel_on (channel_on)
    );

    assign m_tdata = {3'b000, channel_on, level};

endmodule

// File: hdl/nclfsr_front.sv
`timescale 1ns / 1ps

module nclfsr_front
    import nclfsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CYC_W-1:0]  s_cycles,
    input  logic [KIND_W-1:0] s_kind,
    output logic              q_valid,
    input  logic              q_ready,
    output req_t              q_req
);

    logic valid_reg, valid_next;
    req_t req_reg, req_next;
    req_t decoded;

    // classify the request; cycle count only matters for an advance
    always_comb begin
        decoded.cycles = '0;
        case (s_kind)
            KIND_ADVANCE: begin
                decoded.op     = OP_ADVANCE;
                decoded.cycles = s_cycles;
            end
            KIND_LENGTH:   decoded.op = OP_LENGTH;
            KIND_ENVELOPE: decoded.op = OP_ENVELOPE;
            KIND_TRIGGER:  decoded.op = OP_TRIGGER;
            default:       decoded.op = OP_TRIGGER;
        endcase
    end

    assign s_tready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            req_next   = decoded;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        req_reg <= req_next;
    end

    assign q_valid = valid_reg;
    assign q_req   = req_reg;

endmodule

// File: hdl/nclfsr_queue.sv
`timescale 1ns / 1ps

module nclfsr_queue
    import nclfsr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    output logic out_valid,
    input  logic out_ready,
    output req_t out_req
);

    req_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_req   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_req;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == QCNT_W'(QDEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");
`endif

endmodule

// File: hdl/nclfsr_back.sv
`timescale 1ns / 1ps

module nclfsr_back
    import nclfsr_pkg::*;
#(
    parameter int BASE_DIVISOR = BASE_DIVISOR_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  req_t                  q_req,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VOL_W-1:0]      m_level,
    output logic                  m_channel_on
);

    localparam int D_W = $clog2(7 * BASE_DIVISOR + 1);
    localparam int P_W = (D_W + 15 > ACC_W) ? D_W + 15 : ACC_W;
    localparam logic [ACC_W-1:0] PERIOD_RST = ACC_W'(BASE_DIVISOR / 2);

    // configuration registers
    logic [SHIFT_W-1:0] shift_clock_reg;
    logic [RATIO_W-1:0] divide_ratio_reg;
    logic               narrow_mode_reg;
    logic               length_enable_reg;
    logic [SLEN_W-1:0]  sound_length_reg;
    logic [VOL_W-1:0]   initial_volume_reg;
    logic               envelope_up_reg;
    logic [ENV_W-1:0]   envelope_period_reg;

    // channel state
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  period_reg, period_next;
    logic [ACC_W-1:0]  period_cfg_reg, period_cfg_next;
    logic [VOL_W-1:0]  vol_reg, vol_next;
    logic [ENV_W-1:0]  env_cnt_reg, env_cnt_next;
    logic [ENV_W-1:0]  env_per_reg, env_per_next;
    logic              env_up_reg, env_up_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              on_reg, on_next;

    logic              out_valid_reg, out_valid_next;
    logic [VOL_W-1:0]  level_reg, level_next;
    logic              chan_reg, chan_next;

    logic              pop;
    logic [D_W-1:0]    divisor;
    logic [P_W-1:0]    period_wide;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic [ACC_W:0]    acc_diff;
    logic              step_fire;
    logic              fb;
    logic [LFSR_W-1:0] lfsr_shifted;
    logic [ENV_W-1:0]  env_dec;
    logic [LEN_W-1:0]  len_dec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_clock_reg     <= '0;
            divide_ratio_reg    <= '0;
            narrow_mode_reg     <= 1'b0;
            length_enable_reg   <= 1'b0;
            sound_length_reg    <= '0;
            initial_volume_reg  <= '0;
            envelope_up_reg     <= 1'b0;
            envelope_period_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHIFT_CLOCK:     shift_clock_reg     <= cfg_data[SHIFT_W-1:0];
                CFG_DIVIDE_RATIO:    divide_ratio_reg    <= cfg_data[RATIO_W-1:0];
                CFG_NARROW_MODE:     narrow_mode_reg     <= cfg_data[0];
                CFG_LENGTH_ENABLE:   length_enable_reg   <= cfg_data[0];
                CFG_SOUND_LENGTH:    sound_length_reg    <= cfg_data[SLEN_W-1:0];
                CFG_INITIAL_VOLUME:  initial_volume_reg  <= cfg_data[VOL_W-1:0];
                CFG_ENVELOPE_UP:     envelope_up_reg     <= cfg_data[0];
                CFG_ENVELOPE_PERIOD: envelope_period_reg <= cfg_data[ENV_W-1:0];
                default: ;
            endcase
        end
    end

    // step period, registered from the configuration registers; capped so the
    // saturating accumulator can always reach it
    always_comb begin
        if (divide_ratio_reg == '0) begin
            divisor = D_W'(BASE_DIVISOR / 2);
        end else begin
            divisor = D_W'(divide_ratio_reg) * D_W'(BASE_DIVISOR);
        end
        period_wide = P_W'(divisor) << shift_clock_reg;
        if (period_wide > P_W'(ACC_MAX)) begin
            period_cfg_next = ACC_MAX;
        end else begin
            period_cfg_next = period_wide[ACC_W-1:0];
        end
    end

    assign pop     = q_valid && q_ready;
    assign q_ready = !out_valid_reg || m_tready;

    // datapath pieces
    always_comb begin
        acc_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(q_req.cycles);
        acc_sat  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        acc_diff = {1'b0, acc_sat} - {1'b0, period_reg};
        step_fire = !acc_diff[ACC_W];
        fb = lfsr_reg[0] ^ lfsr_reg[1];
        lfsr_shifted = {fb, lfsr_reg[LFSR_W-1:1]};
        if (narrow_mode_reg) begin
            lfsr_shifted[6] = fb;
        end
        env_dec = env_cnt_reg - 1'b1;
        len_dec = len_reg - 1'b1;
    end

    always_comb begin
        lfsr_next    = lfsr_reg;
        acc_next     = acc_reg;
        period_next  = period_reg;
        vol_next     = vol_reg;
        env_cnt_next = env_cnt_reg;
        env_per_next = env_per_reg;
        env_up_next  = env_up_reg;
        len_next     = len_reg;
        on_next      = on_reg;

        if (pop) begin
            case (q_req.op)
                OP_ADVANCE: begin
                    acc_next = acc_sat;
                    if (step_fire) begin
                        acc_next    = acc_diff[ACC_W-1:0];
                        period_next = period_cfg_reg;
                        lfsr_next   = lfsr_shifted;
                    end
                end
                OP_LENGTH: begin
                    if (len_reg != '0) begin
                        len_next = len_dec;
                        if (len_dec == '0 && length_enable_reg) begin
                            on_next = 1'b0;
                        end
                    end
                end
                OP_ENVELOPE: begin
                    if (env_per_reg != '0) begin
                        env_cnt_next = env_dec;
                        if (env_dec == '0) begin
                            env_cnt_next = env_per_reg;
                            if (env_up_reg) begin
                                if (vol_reg != VOL_MAX) vol_next = vol_reg + 1'b1;
                            end else begin
                                if (vol_reg != VOL_MIN) vol_next = vol_reg - 1'b1;
                            end
                        end
                    end
                end
                OP_TRIGGER: begin
                    len_next     = LEN_FULL - LEN_W'(sound_length_reg);
                    period_next  = period_cfg_reg;
                    acc_next     = '0;
                    vol_next     = initial_volume_reg;
                    env_up_next  = envelope_up_reg;
                    env_per_next = envelope_period_reg;
                    env_cnt_next = envelope_period_reg;
                    lfsr_next    = LFSR_SEED;
                    on_next      = 1'b1;
                end
                default: ;
            endcase
        end

        // output register: load on pop, drop when taken
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        chan_next      = chan_reg;
        if (pop) begin
            out_valid_next = 1'b1;
            level_next     = (on_next && !lfsr_next[0]) ? vol_next : '0;
            chan_next      = on_next;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg       <= LFSR_SEED;
            acc_reg        <= '0;
            period_reg     <= PERIOD_RST;
            period_cfg_reg <= PERIOD_RST;
            vol_reg        <= '0;
            env_cnt_reg    <= '0;
            env_per_reg    <= '0;
            env_up_reg     <= 1'b0;
            len_reg        <= '0;
            on_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            lfsr_reg       <= lfsr_next;
            acc_reg        <= acc_next;
            period_reg     <= period_next;
            period_cfg_reg <= period_cfg_next;
            vol_reg        <= vol_next;
            env_cnt_reg    <= env_cnt_next;
            env_per_reg    <= env_per_next;
            env_up_reg     <= env_up_next;
            len_reg        <= len_next;
            on_reg         <= on_next;
            out_valid_reg  <= out_valid_next;
        end
        level_reg <= level_next;
        chan_reg  <= chan_next;
    end

    assign m_tvalid     = out_valid_reg;
    assign m_level      = level_reg;
    assign m_channel_on = chan_reg;

`ifndef NO_ASSERTIONS
    a_silent_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !chan_reg) |-> (level_reg == '0))
        else $error("level nonzero while channel off");

    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        period_reg != '0)
        else $error("step period reached zero");

    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_FULL)
        else $error("length counter above full length");

    a_off_needs_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (on_reg && !on_next) |-> (pop && q_req.op == OP_LENGTH))
        else $error("channel switched off outside a length clock");
`endif

endmodule
